### rtl/bhsk_pkg.sv
// ----------------------------------------------------------------------------
// bhsk_pkg
// Shared types and constants for the bounded heap smallest-k select core.
// ----------------------------------------------------------------------------
package bhsk_pkg;

   localparam int CAPACITY_DEFAULT = 256;
   localparam int ID_WIDTH         = 32;
   localparam int INDEX_WIDTH      = 8;
   localparam int COUNT_OUT_WIDTH  = 9;

   localparam logic [ID_WIDTH-1:0] TOTAL_MAX = '1;

   localparam logic [1:0] OP_OFFER = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   typedef struct packed {
      logic [1:0]             opcode;
      logic [ID_WIDTH-1:0]    pid;
      logic [INDEX_WIDTH-1:0] index;
   } req_type;

   typedef struct packed {
      logic [COUNT_OUT_WIDTH-1:0] held_count;
      logic [ID_WIDTH-1:0]        total_seen;
      logic [ID_WIDTH-1:0]        largest_held;
      logic [ID_WIDTH-1:0]        read_value;
      logic                       accepted;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // latch the request
      logic bump_total;  // count an offer
      logic clear;       // empty heap, zero total
      logic start_up;    // pos = count, count++
      logic start_dn;    // pos = root
      logic issue_up;    // read parent of pos
      logic issue_dn;    // read both children of pos
      logic issue_rd;    // read requested slot
      logic up_step;     // move parent down into pos
      logic dn_step;     // move larger child up into pos
      logic place;       // write identifier at pos
      logic cap_read;    // capture read data
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] opcode;
      logic       above_cursor;
      logic       not_full;
      logic       below_root;
      logic       pos_zero;
      logic       has_left;
      logic       up_go;
      logic       dn_go;
      logic       read_hit;
   } stat_type;

endpackage

### rtl/bhsk_ram.sv
// ----------------------------------------------------------------------------
// bhsk_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bhsk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### rtl/bhsk_datapath.sv
// ----------------------------------------------------------------------------
// bhsk_datapath
// Heap storage, position and count registers, compares for the sift loops.
// ----------------------------------------------------------------------------
module bhsk_datapath #(
   parameter int CAPACITY = bhsk_pkg::CAPACITY_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  bhsk_pkg::req_type req_data,
   input  logic              csr_we,
   input  logic [31:0]       csr_wdata,
   input  bhsk_pkg::cmd_type cmd,
   output bhsk_pkg::stat_type stat,
   output bhsk_pkg::rsp_type rsp_data
);
   import bhsk_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = CW + 1;
   localparam int MW = (CW > INDEX_WIDTH) ? CW : INDEX_WIDTH;

   logic [1:0]             op_ff;
   logic [ID_WIDTH-1:0]    pid_ff;
   logic [INDEX_WIDTH-1:0] index_ff;
   logic [ID_WIDTH-1:0]    cursor_ff;
   logic [CW-1:0]          count_ff, count_in;
   logic [ID_WIDTH-1:0]    total_ff, total_in;
   logic [AW-1:0]          pos_ff, pos_in;
   logic [ID_WIDTH-1:0]    root_ff;
   logic [ID_WIDTH-1:0]    read_value_ff;
   logic                   accept_ff;

   logic [AW-1:0]       parent;
   logic [XW-1:0]       left_x, right_x;
   logic                has_right, pick_right;
   logic [ID_WIDTH-1:0] child_val;
   logic [AW-1:0]       child_pos;
   logic [ID_WIDTH-1:0] rd_a, rd_b;
   logic [AW-1:0]       rd_addr_a, rd_addr_b;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [ID_WIDTH-1:0] wr_data;

   assign parent     = AW'((pos_ff - AW'(1)) >> 1);
   assign left_x     = XW'({pos_ff, 1'b1});
   assign right_x    = left_x + XW'(1);
   assign has_right  = right_x < XW'(count_ff);
   assign pick_right = has_right && (rd_b > rd_a);
   assign child_val  = pick_right ? rd_b : rd_a;
   assign child_pos  = pick_right ? AW'(right_x) : AW'(left_x);

   assign rd_addr_a = cmd.issue_rd ? AW'(index_ff) :
                      cmd.issue_up ? parent :
                      cmd.issue_dn ? AW'(left_x) : pos_ff;
   assign rd_addr_b = AW'(right_x);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = pid_ff;
      priority if (cmd.up_step) begin
         wr_en   = 1'b1;
         wr_data = rd_a;
      end else if (cmd.dn_step) begin
         wr_en   = 1'b1;
         wr_data = child_val;
      end else if (cmd.place) begin
         wr_en   = 1'b1;
      end
   end

   bhsk_ram #(
      .WIDTH (ID_WIDTH),
      .DEPTH (CAPACITY)
   ) u_heap_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_b)
   );

   always_comb begin
      count_in = count_ff;
      total_in = total_ff;
      pos_in   = pos_ff;
      if (cmd.clear) begin
         count_in = '0;
         total_in = '0;
      end
      if (cmd.bump_total && (total_ff != TOTAL_MAX)) begin
         total_in = total_ff + ID_WIDTH'(1);
      end
      if (cmd.start_up) begin
         pos_in   = AW'(count_ff);
         count_in = count_ff + CW'(1);
      end
      if (cmd.start_dn) begin
         pos_in = '0;
      end
      if (cmd.up_step) begin
         pos_in = parent;
      end
      if (cmd.dn_step) begin
         pos_in = child_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         total_ff  <= '0;
         cursor_ff <= '0;
      end else begin
         count_ff <= count_in;
         total_ff <= total_in;
         if (csr_we) begin
            cursor_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (cmd.load) begin
         op_ff         <= req_data.opcode;
         pid_ff        <= req_data.pid;
         index_ff      <= req_data.index;
         read_value_ff <= '0;
         accept_ff     <= 1'b0;
      end
      if (cmd.cap_read) begin
         read_value_ff <= rd_a;
      end
      if (cmd.place) begin
         accept_ff <= 1'b1;
      end
      // mirror slot 0 so the root is always at hand
      if (wr_en && (wr_addr == '0)) begin
         root_ff <= wr_data;
      end
   end

   always_comb begin
      stat.opcode       = op_ff;
      stat.above_cursor = pid_ff > cursor_ff;
      stat.not_full     = count_ff < CW'(CAPACITY);
      stat.below_root   = pid_ff < root_ff;
      stat.pos_zero     = pos_ff == '0;
      stat.has_left     = left_x < XW'(count_ff);
      stat.up_go        = rd_a < pid_ff;
      stat.dn_go        = child_val > pid_ff;
      stat.read_hit     = MW'(index_ff) < MW'(count_ff);
   end

   always_comb begin
      rsp_data.held_count   = COUNT_OUT_WIDTH'(count_ff);
      rsp_data.total_seen   = total_ff;
      rsp_data.largest_held = (count_ff != '0) ? root_ff : '0;
      rsp_data.read_value   = read_value_ff;
      rsp_data.accepted     = accept_ff;
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("heap count above capacity");

   a_accept_offer : assert property (@(posedge clock) disable iff (reset)
      accept_ff |-> (op_ff == OP_OFFER))
      else $error("accepted flag set on a non-offer request");

   a_clear_empties : assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (count_ff == '0) && (total_ff == '0))
      else $error("clear did not empty heap and total");

endmodule

### rtl/bhsk_ctrl.sv
// ----------------------------------------------------------------------------
// bhsk_ctrl
// Sequencer for offer, clear and read requests; drives the sift loops.
// ----------------------------------------------------------------------------
module bhsk_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output logic               rsp_valid,
   input  bhsk_pkg::stat_type stat,
   output bhsk_pkg::cmd_type  cmd
);
   import bhsk_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_DECODE = 9'b000000010,
      S_UP_RD  = 9'b000000100,
      S_UP_CMP = 9'b000001000,
      S_DN_RD  = 9'b000010000,
      S_DN_CMP = 9'b000100000,
      S_RD_CAP = 9'b001000000,
      S_PLACE  = 9'b010000000,
      S_RESP   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_RESP;
            priority if (stat.opcode == OP_OFFER) begin
               cmd.bump_total = 1'b1;
               priority if (!stat.above_cursor) begin
                  state_in = S_RESP;
               end else if (stat.not_full) begin
                  cmd.start_up = 1'b1;
                  state_in     = S_UP_RD;
               end else if (stat.below_root) begin
                  cmd.start_dn = 1'b1;
                  state_in     = S_DN_RD;
               end else begin
                  state_in = S_RESP;
               end
            end else if (stat.opcode == OP_CLEAR) begin
               cmd.clear = 1'b1;
            end else if (stat.opcode == OP_READ) begin
               if (stat.read_hit) begin
                  cmd.issue_rd = 1'b1;
                  state_in     = S_RD_CAP;
               end
            end else begin
               state_in = S_RESP;
            end
         end
         S_UP_RD: begin
            if (stat.pos_zero) begin
               state_in = S_PLACE;
            end else begin
               cmd.issue_up = 1'b1;
               state_in     = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (stat.up_go) begin
               cmd.up_step = 1'b1;
               state_in    = S_UP_RD;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_DN_RD: begin
            if (stat.has_left) begin
               cmd.issue_dn = 1'b1;
               state_in     = S_DN_CMP;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_DN_CMP: begin
            if (stat.dn_go) begin
               cmd.dn_step = 1'b1;
               state_in    = S_DN_RD;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_RD_CAP: begin
            cmd.cap_read = 1'b1;
            state_in     = S_RESP;
         end
         S_PLACE: begin
            cmd.place = 1'b1;
            state_in  = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_RESP;

endmodule

### rtl/bounded_heap_smallest_k_select_core.sv
// ----------------------------------------------------------------------------
// bounded_heap_smallest_k_select_core
// Keeps the CAPACITY smallest identifiers above a cursor in a max-heap.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays
// high until the response has been shown. Every request yields exactly one
// response, on rsp_data for the single cycle in which rsp_valid is high. The
// receiver cannot stall: capture the response in that cycle or lose it.
// Clear, an unused opcode, a rejected offer and a read of an unheld slot go
// from decode straight to the response; a read of a held slot first captures
// the slot. An offer that enters the heap sifts up into a free slot, or down
// from the root when the heap is full, and then places its identifier. A sift
// that runs all the way to the root or to a leaf skips the final compare.
// Each level costs one read of the heap RAM (both children at once on the
// way down) and one compare with a write-back. The next request may start
// the cycle after the strobe. The heap RAM needs no clearing after reset:
// only slots below the held count are ever read. The cursor is written
// through csr_we / csr_wdata; the user must write it only while idle, as
// the core itself does not enforce this.
// ----------------------------------------------------------------------------
module bounded_heap_smallest_k_select_core #(
   parameter int CAPACITY = bhsk_pkg::CAPACITY_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bhsk_pkg::req_type req_data,
   output logic              rsp_valid,
   output bhsk_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [31:0]       csr_wdata
);
   import bhsk_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer: decode the request, run a sift loop, strobe the response
   bhsk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   // heap RAM, count, total, cursor and the compares feeding the sequencer
   bhsk_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

   // one strobe per request, never two in a row
   a_single_strobe : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   // an accepted request holds off the next one
   a_busy_after_start : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request");

   // a load only happens on an accepted request
   a_load_on_accept : assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (start && !busy))
      else $error("request latched without handshake");

endmodule

### tb/bounded_heap_smallest_k_select_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smallest-k heap select checker
// Watches the request, response and cursor ports of the select core, keeps a
// private copy of the heap, count, total and cursor, and compares every
// response field by field against the status predicted for its request.
// ----------------------------------------------------------------------------
module bhsk_select_checker #(
   parameter int CAPACITY = bhsk_pkg::CAPACITY_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  bhsk_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  bhsk_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [31:0]       csr_wdata,
   output int                fail_count,
   output int                outstanding
);
   import bhsk_pkg::*;

   logic [ID_WIDTH-1:0] heap_ids [CAPACITY];
   int unsigned         held;
   logic [ID_WIDTH-1:0] seen;
   logic [ID_WIDTH-1:0] cursor_now;
   rsp_type             status_q [$];
   rsp_type             want;

   // Place id in the max-heap: sift up into a free slot, or replace the root
   // and sift down when full. Returns 1 when the id was kept.
   function automatic logic heap_insert(logic [ID_WIDTH-1:0] id);
      int unsigned pos;
      int unsigned parent;
      int unsigned child;
      if (held < CAPACITY) begin
         pos = held;
         held++;
         while (pos != 0) begin
            parent = (pos - 1) / 2;
            if (!(heap_ids[parent] < id)) break;
            heap_ids[pos] = heap_ids[parent];
            pos = parent;
         end
      end else begin
         if (id >= heap_ids[0]) return 1'b0;
         pos = 0;
         while (2 * pos + 1 < held) begin
            child = 2 * pos + 1;
            if (child + 1 < held && heap_ids[child + 1] > heap_ids[child]) child++;
            if (heap_ids[child] <= id) break;
            heap_ids[pos] = heap_ids[child];
            pos = child;
         end
      end
      heap_ids[pos] = id;
      return 1'b1;
   endfunction

   function automatic rsp_type predict_status(req_type r);
      rsp_type o;
      o.read_value = '0;
      o.accepted   = 1'b0;
      case (r.opcode)
         OP_OFFER: begin
            if (seen != TOTAL_MAX) seen++;
            if (r.pid > cursor_now) o.accepted = heap_insert(r.pid);
         end
         OP_CLEAR: begin
            held = 0;
            seen = '0;
         end
         OP_READ: begin
            if (r.index < held && r.index < CAPACITY) o.read_value = heap_ids[r.index];
         end
         default: ;
      endcase
      o.held_count   = held[COUNT_OUT_WIDTH-1:0];
      o.total_seen   = seen;
      o.largest_held = (held != 0) ? heap_ids[0] : '0;
      return o;
   endfunction

   task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (act_val !== exp_val) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: %s mismatch, expected %h got %h", $time, name, exp_val, act_val);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fail_count = 0;
         held       = 0;
         seen       = '0;
         cursor_now = '0;
         status_q.delete();
      end else begin
         if (rsp_valid) begin
            if (status_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: response with no request pending: %p", $time, rsp_data);
            end else begin
               want = status_q.pop_front();
               check_field("held_count", 32'(want.held_count), 32'(rsp_data.held_count));
               check_field("total_seen", want.total_seen, rsp_data.total_seen);
               check_field("largest_held", want.largest_held, rsp_data.largest_held);
               check_field("read_value", want.read_value, rsp_data.read_value);
               check_field("accepted", 32'(want.accepted), 32'(rsp_data.accepted));
            end
         end
         if (csr_we) cursor_now = csr_wdata;
         if (start && !busy) status_q.push_back(predict_status(req_data));
      end
      outstanding = status_q.size();
   end

endmodule

### tb/bounded_heap_smallest_k_select_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smallest-k heap select core testbench
// Drives directed and random offer, clear and read requests in bursts across
// several cursor settings, and leaves all prediction and comparison to the
// checker instantiated beside the core.
// ----------------------------------------------------------------------------
module bounded_heap_smallest_k_select_core_tb;
   import bhsk_pkg::*;

   // opcode 3 is not decoded by the core; keep it in the stimulus anyway
   localparam logic [1:0] OP_UNUSED   = 2'd3;
   // cycles with neither a request nor a response before giving up
   localparam int         STALL_LIMIT = 1000;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [31:0] csr_wdata;

   int          fail_count;
   int          outstanding;
   int          idle_cycles;
   logic [31:0] cursor_value;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   bounded_heap_smallest_k_select_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   bhsk_select_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Watchdog: restart on every accepted request or response.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Present a request from a falling edge, hold it until the core takes it,
   // then return on the next falling edge with start still high.
   task automatic send_request(req_type item);
      req_data = item;
      start    = 1'b1;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      @(negedge clock);
   endtask

   task automatic send_fields(logic [1:0] op, logic [31:0] pid, logic [7:0] index);
      req_type item;
      item.opcode = op;
      item.pid    = pid;
      item.index  = index;
      send_request(item);
   endtask

   // Drop start and hold until every pending response has come back.
   task automatic drain_responses();
      start = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Drains first: every request answers, so the core is idle for the write.
   task automatic write_cursor(logic [31:0] value);
      drain_responses();
      cursor_value = value;
      csr_wdata    = value;
      csr_we       = 1'b1;
      @(negedge clock);
      csr_we       = 1'b0;
   endtask

   // Mix of identifier shapes: full range, a small range that forces
   // duplicates and root replacement, the top of the range, and values
   // hugging the cursor on both sides.
   function automatic logic [31:0] pick_id();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5:       return $urandom_range(0, 1023);
         6:          return 32'hFFFF_FFFF - $urandom_range(0, 15);
         7:          return cursor_value + $urandom_range(0, 4) - 2;
         8:          return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
         default:    return $urandom & ((32'h1 << $urandom_range(0, 31)) - 1);
      endcase
   endfunction

   function automatic req_type make_request(int offer_pct, int clear_pct);
      req_type r;
      int      roll;
      roll    = $urandom_range(0, 99);
      r.pid   = pick_id();
      r.index = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) :
                                       8'($urandom_range(0, 15));
      if (roll < offer_pct)                  r.opcode = OP_OFFER;
      else if (roll < offer_pct + clear_pct) r.opcode = OP_CLEAR;
      else if (roll < 98)                    r.opcode = OP_READ;
      else                                   r.opcode = OP_UNUSED;
      return r;
   endfunction

   // Send requests in bursts with random idle gaps between them, and now and
   // then hold off until the core has answered everything.
   task automatic run_phase(int count, int offer_pct, int clear_pct);
      int burst_left;
      burst_left = $urandom_range(1, 40);
      for (int k = 0; k < count; k++) begin
         send_request(make_request(offer_pct, clear_pct));
         burst_left--;
         if ($urandom_range(0, 49) == 0) begin
            drain_responses();
         end else if (burst_left <= 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
            burst_left = $urandom_range(1, 40);
         end
      end
   endtask

   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      csr_we       = 1'b0;
      csr_wdata    = '0;
      cursor_value = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Directed: cursor at its reset value of zero.
      send_fields(OP_OFFER, 32'h0000_0000, 8'h00);  // not above cursor
      send_fields(OP_OFFER, 32'hFFFF_FFFF, 8'hFF);
      send_fields(OP_OFFER, 32'h0000_0001, 8'h00);
      send_fields(OP_OFFER, 32'h8000_0000, 8'h00);
      send_fields(OP_OFFER, 32'hFFFF_FFFF, 8'h00);  // duplicate of the root
      send_fields(OP_READ, 32'hFFFF_FFFF, 8'h00);
      send_fields(OP_READ, 32'h0000_0000, 8'h03);
      send_fields(OP_READ, 32'h0000_0000, 8'h04);   // first unheld slot
      send_fields(OP_READ, 32'h0000_0000, 8'hFF);   // far unheld slot
      send_fields(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF);
      send_fields(OP_UNUSED, 32'h0000_0000, 8'h00);
      send_fields(OP_CLEAR, 32'hA5A5_5A5A, 8'h81);
      send_fields(OP_READ, 32'h0000_0000, 8'h00);   // read after clear
      send_fields(OP_OFFER, 32'h0000_0005, 8'h00);

      // Cursor one below the top: only the largest identifier survives.
      write_cursor(32'hFFFF_FFFE);
      send_fields(OP_OFFER, 32'hFFFF_FFFE, 8'h00);  // equal to cursor
      send_fields(OP_OFFER, 32'hFFFF_FFFF, 8'h00);
      send_fields(OP_OFFER, 32'h0000_0000, 8'h00);
      send_fields(OP_READ, 32'h0000_0000, 8'h01);

      // Note: a saturated total needs 2^32 offers and is out of reach here.

      // Fill the heap to capacity and keep offering so the root gets replaced.
      write_cursor(32'h0000_0000);
      send_fields(OP_CLEAR, 32'h0, 8'h0);
      run_phase(380, 85, 0);

      // Raise the cursor under a full heap.
      write_cursor($urandom_range(256, 4096));
      run_phase(150, 70, 0);

      // Top cursor: every offer is counted and refused.
      write_cursor(32'hFFFF_FFFF);
      run_phase(40, 60, 2);

      // Random cursor with occasional clears.
      write_cursor($urandom);
      run_phase(200, 65, 3);

      // Back to zero, read-heavy.
      write_cursor(32'h0000_0000);
      run_phase(80, 40, 2);

      drain_responses();
      repeat (40) @(negedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
